>>> rtl/core/mesi_pkg.sv
package mesi_pkg;

  // configuration of the coherence domain
  localparam int NUM_CORES   = 2;
  localparam int NUM_LINES   = 16;
  localparam int DATA_WIDTH  = 32;

  // fixed widths of the request and response fields
  localparam int REQ_IN_W    = 1;
  localparam int ADDR_IN_W   = 4;
  localparam int WORD_W      = 32;

  // derived widths
  localparam int CORE_W      = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
  localparam int LINE_W      = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;

  // request queue between front and back end
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_I = 2'd0,
    ST_S = 2'd1,
    ST_E = 2'd2,
    ST_M = 2'd3
  } mesi_state_t;

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } mesi_op_t;

  typedef enum logic {
    BK_IDLE,
    BK_RESOLVE
  } mesi_back_state_t;

  typedef struct packed {
    logic                 op;
    logic [REQ_IN_W-1:0]  requester;
    logic [ADDR_IN_W-1:0] line_address;
    logic [WORD_W-1:0]    write_data;
  } mesi_req_t;

  typedef struct packed {
    logic [1:0]        new_state;
    logic [WORD_W-1:0] read_data;
    logic              was_hit;
    logic              peer_supplied;
  } mesi_rsp_t;

  // decoded request as held in the queue
  typedef struct packed {
    mesi_op_t              op;
    logic [CORE_W-1:0]     core;
    logic [LINE_W-1:0]     line;
    logic [DATA_WIDTH-1:0] wdata;
  } mesi_cmd_t;

  typedef logic [LINE_W-1:0] line_map_t [2**ADDR_IN_W];

  // folds every incoming line address onto the implemented lines
  function automatic line_map_t build_line_map();
    line_map_t m;
    for (int a = 0; a < 2**ADDR_IN_W; a++) begin
      m[a] = LINE_W'(a % NUM_LINES);
    end
    return m;
  endfunction

  localparam line_map_t LINE_MAP = build_line_map();

endpackage

>>> rtl/core/mesi_ram.sv
module mesi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                           wr_data,
  input  logic                                       rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                           rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single write port, registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/core/mesi_front.sv
module mesi_front import mesi_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  mesi_req_t in_data,
  output logic      q_valid,
  input  logic      q_pop,
  output mesi_cmd_t q_head
);

  mesi_cmd_t         cmd;
  mesi_cmd_t         slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;

  // decode the incoming request onto core and line indices
  always_comb begin
    cmd.op    = mesi_op_t'(in_data.op);
    cmd.core  = CORE_W'(in_data.requester);
    cmd.line  = LINE_MAP[in_data.line_address];
    cmd.wdata = DATA_WIDTH'(in_data.write_data);
  end

  // queue handshake
  assign in_stall = (count == QCNT_W'(QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != '0);
  assign pop      = q_pop && q_valid;
  assign q_head   = slots[rd_ptr];

  // queue pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= cmd;
    end
  end

endmodule

>>> rtl/core/mesi_back.sv
module mesi_back import mesi_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      q_valid,
  output logic      q_pop,
  input  mesi_cmd_t q_head,
  output logic      out_valid,
  input  logic      out_stall,
  output mesi_rsp_t out_data
);

  mesi_back_state_t      state;
  mesi_back_state_t      state_next;
  mesi_cmd_t             cur;
  logic                  rd_en;
  logic                  resolve;
  logic                  out_free;

  mesi_state_t           state_tab [NUM_LINES][NUM_CORES];
  logic                  bs_valid  [NUM_LINES];
  logic [DATA_WIDTH-1:0] core_rdata [NUM_CORES];
  logic [DATA_WIDTH-1:0] bs_rdata;

  mesi_state_t           row      [NUM_CORES];
  mesi_state_t           row_next [NUM_CORES];
  mesi_state_t           my_st;
  mesi_state_t           new_st;
  logic                  hit;
  logic                  found;
  logic                  sharers;
  logic [DATA_WIDTH-1:0] supply_word;
  logic [DATA_WIDTH-1:0] word;
  logic                  data_we;
  logic                  bs_we;
  logic [NUM_CORES-1:0]  data_wr;

  assign out_free = !out_valid || !out_stall;

  // sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer: issue the lookup, then resolve once the result slot is free
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    rd_en      = 1'b0;
    resolve    = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          rd_en      = 1'b1;
          state_next = BK_RESOLVE;
        end
      end
      BK_RESOLVE: begin
        if (out_free) begin
          resolve    = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // current request
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_head;
    end
  end

  // snoop all peers of the addressed line and work out the transition
  always_comb begin
    row         = state_tab[cur.line];
    row_next    = row;
    my_st       = row[cur.core];
    hit         = (my_st != ST_I);
    found       = 1'b0;
    sharers     = 1'b0;
    supply_word = '0;
    word        = core_rdata[cur.core];
    new_st      = my_st;
    data_we     = 1'b0;
    bs_we       = 1'b0;

    // lowest numbered modified peer supplies the line
    for (int c = 0; c < NUM_CORES; c++) begin
      if (CORE_W'(c) != cur.core && row[c] == ST_M && !found) begin
        supply_word = core_rdata[c];
        found       = 1'b1;
      end
    end

    if (cur.op == OP_WRITE) begin
      for (int c = 0; c < NUM_CORES; c++) begin
        row_next[c] = ST_I;
      end
      row_next[cur.core] = ST_M;
      word               = cur.wdata;
      new_st             = ST_M;
      data_we            = 1'b1;
      found              = 1'b0;
    end else if (!hit) begin
      for (int c = 0; c < NUM_CORES; c++) begin
        if (CORE_W'(c) != cur.core) begin
          if (row[c] == ST_M || row[c] == ST_E) begin
            row_next[c] = ST_S;
          end
          if (row[c] != ST_I) begin
            sharers = 1'b1;
          end
        end
      end
      if (found) begin
        word = supply_word;
      end else begin
        word = bs_valid[cur.line] ? bs_rdata : '0;
      end
      row_next[cur.core] = sharers ? ST_S : ST_E;
      new_st             = sharers ? ST_S : ST_E;
      data_we            = 1'b1;
      bs_we              = found;
    end
  end

  // per-core write strobes for the line data
  always_comb begin
    for (int c = 0; c < NUM_CORES; c++) begin
      data_wr[c] = resolve && data_we && (cur.core == CORE_W'(c));
    end
  end

  // line state table and backing store valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int l = 0; l < NUM_LINES; l++) begin
        bs_valid[l] <= 1'b0;
        for (int c = 0; c < NUM_CORES; c++) begin
          state_tab[l][c] <= ST_I;
        end
      end
    end else if (resolve) begin
      state_tab[cur.line] <= row_next;
      if (bs_we) begin
        bs_valid[cur.line] <= 1'b1;
      end
    end
  end

  // line data, one memory per core
  for (genvar c = 0; c < NUM_CORES; c++) begin : g_core
    mesi_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (NUM_LINES)
    ) u_data (
      .clk     (clk),
      .wr_en   (data_wr[c]),
      .wr_addr (cur.line),
      .wr_data (word),
      .rd_en   (rd_en),
      .rd_addr (q_head.line),
      .rd_data (core_rdata[c])
    );
  end

  // backing store, takes write-backs from modified peers
  mesi_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (NUM_LINES)
  ) u_backing (
    .clk     (clk),
    .wr_en   (resolve && bs_we),
    .wr_addr (cur.line),
    .wr_data (supply_word),
    .rd_en   (rd_en),
    .rd_addr (q_head.line),
    .rd_data (bs_rdata)
  );

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (resolve) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (resolve) begin
      out_data.new_state     <= new_st;
      out_data.read_data     <= WORD_W'(word);
      out_data.was_hit       <= hit;
      out_data.peer_supplied <= found;
    end
  end

endmodule

>>> rtl/core/mesi_snoop_coherence.sv
// MESI snooping coherence for a set of private caches over one shared backing store. Each
// request reads or writes one line for one core and returns one response with the core's
// new line state, the word it now holds, whether it already had a valid copy and whether a
// Modified peer supplied the word. A front end decodes requests into a two-entry queue, so
// new requests are taken while a response still waits; the back end handles one request at
// a time: it first looks up the registered line data and backing store memories, then, once
// the response slot is free, snoops all peers' states for the line in parallel and commits
// the result before it takes the next request. After reset every line is
// Invalid in every core and the backing store reads as zero; no clearing pass is needed.
module mesi_snoop_coherence import mesi_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  mesi_req_t req_data,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output mesi_rsp_t rsp_data
);

  logic      q_valid;
  logic      q_pop;
  mesi_cmd_t q_head;

  // request decode and queue
  mesi_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req_valid),
    .in_stall (req_stall),
    .in_data  (req_data),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_head   (q_head)
  );

  // snoop, state update and response
  mesi_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_head    (q_head),
    .out_valid (rsp_valid),
    .out_stall (rsp_stall),
    .out_data  (rsp_data)
  );

endmodule

>>> rtl/core/mesi_checker.sv
module mesi_checker import mesi_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      req_stall,
  input logic      rsp_valid,
  input logic      rsp_stall,
  input mesi_rsp_t rsp_data
);

  // a stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
    else $error("stalled response changed");

  // every access leaves the requester with a valid copy
  a_state_valid: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_data.new_state != ST_I)
    else $error("response with invalid line state");

  // a peer supply only happens on a read miss and leaves the line shared
  a_supply: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.peer_supplied |-> !rsp_data.was_hit && rsp_data.new_state == ST_S)
    else $error("peer supply on hit or without sharing");

  // reset empties the queue and the response slot
  a_reset: assert property (@(posedge clk)
    rst |=> !rsp_valid && !req_stall)
    else $error("not empty after reset");

endmodule

bind mesi_snoop_coherence mesi_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp_data  (rsp_data)
);
